>>> rtl/core/iafdm_pkg.sv
// Shared types, opcodes and constants for the 64-bit integer ALU.
package iafdm_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CMD_W = 4;
  localparam int unsigned ERR_W = 2;
  localparam int unsigned SHAMT_W = 6;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_FDIV = 4'd3,
    OP_MOD = 4'd4, OP_AND = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7,
    OP_NOT = 4'd8, OP_SHL = 4'd9, OP_SHR = 4'd10, OP_EQ = 4'd11,
    OP_NEQ = 4'd12, OP_LT = 4'd13, OP_LE = 4'd14, OP_NEG = 4'd15
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_SHIFT = 2'd2
  } err_t;

  // Execution unit chosen by the front end
  typedef enum logic [1:0] {
    UNIT_SIMPLE = 2'd0,
    UNIT_MUL    = 2'd1,
    UNIT_DIV    = 2'd2
  } unit_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     result_is_bool;
    logic [ERR_W-1:0]         error;
  } out_item_t;

  // Classified operation passed from front to back
  typedef struct packed {
    unit_t                    unit;
    logic                     is_mod;
    out_item_t                early;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } task_t;

endpackage

>>> rtl/core/integer_alu_floor_div_mod.sv
// Top level of the 64-bit signed integer ALU with floor division and modulo.
// Simple operations (add, sub, logic, shifts, compares, neg, and all
// error cases) take one item per cycle while full stays low; each result
// passes the front-end register, the task queue and the result queue.
// Multiply holds the back end through split 32x32 partial products, a sum
// and a fix-up step, and floor division or modulo hold it while a restoring
// divider makes one quotient bit per cycle. Results always leave
// in input order; a task queue between front and back lets the input side
// keep accepting meanwhile, until that queue fills.
module integer_alu_floor_div_mod #(
  parameter int unsigned QueueDepth = iafdm_pkg::QUEUE_DEPTH,
  parameter int unsigned OutDepth = iafdm_pkg::OUT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iafdm_pkg::in_item_t  in_item,
  input  logic                 push,
  output logic                 full,
  output iafdm_pkg::out_item_t out_item,
  output logic                 empty,
  input  logic                 pop
);

  iafdm_pkg::task_t     f_task, q_task;
  iafdm_pkg::out_item_t b_res;
  logic f_valid, q_full, q_empty, q_pop, b_valid, o_full;

  iafdm_front u_front (
    .clk, .rst_n, .in_item, .in_push(push), .in_full(full),
    .tq_data(f_task), .tq_valid(f_valid), .tq_ready(~q_full)
  );

  iafdm_queue #(.WIDTH($bits(iafdm_pkg::task_t)), .DEPTH(QueueDepth)) u_tq (
    .clk, .rst_n, .wr_data(f_task), .wr_en(f_valid), .full(q_full),
    .rd_data(q_task), .rd_en(q_pop), .empty(q_empty)
  );

  iafdm_back u_back (
    .clk, .rst_n, .tq_data(q_task), .tq_empty(q_empty), .tq_pop(q_pop),
    .res_data(b_res), .res_valid(b_valid), .res_full(o_full)
  );

  iafdm_queue #(.WIDTH($bits(iafdm_pkg::out_item_t)), .DEPTH(OutDepth)) u_oq (
    .clk, .rst_n, .wr_data(b_res), .wr_en(b_valid), .full(o_full),
    .rd_data(out_item), .rd_en(pop), .empty(empty)
  );

endmodule

>>> rtl/core/iafdm_front.sv
// Front end: accepts items, computes simple ops, classifies the rest.
module iafdm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  iafdm_pkg::in_item_t in_item,
  input  logic                in_push,
  output logic                in_full,
  output iafdm_pkg::task_t    tq_data,
  output logic                tq_valid,
  input  logic                tq_ready
);

  iafdm_pkg::task_t tsk_r, tsk_nxt;
  logic             vld_r;
  logic             take;

  assign in_full = vld_r & ~tq_ready;
  assign take = in_push & ~in_full;
  assign tq_data = tsk_r;
  assign tq_valid = vld_r;

  // Decode and simple datapath
  always_comb begin
    logic signed [iafdm_pkg::DATA_W-1:0] a, b;
    logic [iafdm_pkg::SHAMT_W-1:0]       sh;
    logic                                sh_bad;
    a = in_item.operand_a;
    b = in_item.operand_b;
    sh = b[iafdm_pkg::SHAMT_W-1:0];
    sh_bad = |b[iafdm_pkg::DATA_W-1:iafdm_pkg::SHAMT_W];
    tsk_nxt.unit = iafdm_pkg::UNIT_SIMPLE;
    tsk_nxt.is_mod = 1'b0;
    tsk_nxt.operand_a = a;
    tsk_nxt.operand_b = b;
    tsk_nxt.early.result = '0;
    tsk_nxt.early.result_is_bool = 1'b0;
    tsk_nxt.early.error = iafdm_pkg::ERR_NONE;
    case (iafdm_pkg::op_t'(in_item.cmd))
      iafdm_pkg::OP_ADD: tsk_nxt.early.result = a + b;
      iafdm_pkg::OP_SUB: tsk_nxt.early.result = a - b;
      iafdm_pkg::OP_MUL: tsk_nxt.unit = iafdm_pkg::UNIT_MUL;
      iafdm_pkg::OP_FDIV, iafdm_pkg::OP_MOD: begin
        tsk_nxt.is_mod = (in_item.cmd == iafdm_pkg::OP_MOD);
        if (b == '0) tsk_nxt.early.error = iafdm_pkg::ERR_DIV0;
        else tsk_nxt.unit = iafdm_pkg::UNIT_DIV;
      end
      iafdm_pkg::OP_AND: tsk_nxt.early.result = a & b;
      iafdm_pkg::OP_OR:  tsk_nxt.early.result = a | b;
      iafdm_pkg::OP_XOR: tsk_nxt.early.result = a ^ b;
      iafdm_pkg::OP_NOT: tsk_nxt.early.result = ~a;
      iafdm_pkg::OP_SHL, iafdm_pkg::OP_SHR: begin
        if (sh_bad) tsk_nxt.early.error = iafdm_pkg::ERR_SHIFT;
        else if (in_item.cmd == iafdm_pkg::OP_SHL) tsk_nxt.early.result = a << sh;
        else tsk_nxt.early.result = a >> sh;
      end
      iafdm_pkg::OP_EQ: begin
        tsk_nxt.early.result = {{(iafdm_pkg::DATA_W-1){1'b0}}, a == b};
        tsk_nxt.early.result_is_bool = 1'b1;
      end
      iafdm_pkg::OP_NEQ: begin
        tsk_nxt.early.result = {{(iafdm_pkg::DATA_W-1){1'b0}}, a != b};
        tsk_nxt.early.result_is_bool = 1'b1;
      end
      iafdm_pkg::OP_LT: begin
        tsk_nxt.early.result = {{(iafdm_pkg::DATA_W-1){1'b0}}, a < b};
        tsk_nxt.early.result_is_bool = 1'b1;
      end
      iafdm_pkg::OP_LE: begin
        tsk_nxt.early.result = {{(iafdm_pkg::DATA_W-1){1'b0}}, a <= b};
        tsk_nxt.early.result_is_bool = 1'b1;
      end
      default: tsk_nxt.early.result = -a;
    endcase
  end

  // Pipeline register toward the task queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (tq_ready) begin
      vld_r <= 1'b0;
    end
    if (take) tsk_r <= tsk_nxt;
  end

endmodule

>>> rtl/core/iafdm_queue.sv
// Small synchronous FIFO, used for tasks and results.
module iafdm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             wr_en,
  output logic             full,
  output logic [WIDTH-1:0] rd_data,
  input  logic             rd_en,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             do_wr, do_rd;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en & ~full;
  assign do_rd = rd_en & ~empty;
  assign rd_data = mem_r[rp_r];

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

>>> rtl/core/iafdm_back.sv
// Back end: passes simple results, runs the multi-step multiplier and floor divider, merges results in order.
module iafdm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iafdm_pkg::task_t     tq_data,
  input  logic                 tq_empty,
  output logic                 tq_pop,
  output iafdm_pkg::out_item_t res_data,
  output logic                 res_valid,
  input  logic                 res_full
);

  localparam int unsigned W = iafdm_pkg::DATA_W;
  localparam int unsigned HW = W / 2;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_DIV, S_FIX, S_DONE
  } state_t;

  state_t                 st_r;
  iafdm_pkg::task_t       t_r;
  logic [W-1:0]           ll_r, lh_r, hl_r, sum_r;
  logic [W-1:0]           ua_r, ub_r, q_r, rem_r;
  logic [CW-1:0]          cnt_r;
  logic [W-1:0]           res_r;
  logic                   out_v_r;
  logic [W:0]             trial;
  logic [W-1:0]           rem_sh;
  logic                   aneg, bneg;

  assign aneg = t_r.operand_a[W-1];
  assign bneg = t_r.operand_b[W-1];
  assign rem_sh = {rem_r[W-2:0], ua_r[W-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, ub_r};

  // Simple items pass straight through when the back end is idle
  assign tq_pop = (st_r == S_IDLE) & ~tq_empty &
                  ((tq_data.unit != iafdm_pkg::UNIT_SIMPLE) | ~res_full);
  assign res_valid = ((st_r == S_IDLE) & ~tq_empty &
                      (tq_data.unit == iafdm_pkg::UNIT_SIMPLE)) | out_v_r;

  always_comb begin
    if (out_v_r) begin
      res_data.result = res_r;
      res_data.result_is_bool = 1'b0;
      res_data.error = iafdm_pkg::ERR_NONE;
    end else begin
      res_data = tq_data.early;
    end
  end

  // Sequencer: a multiply steps through S_MUL1, S_MUL2, S_FIX and S_DONE, a divide through S_DIV, S_FIX and S_DONE
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (tq_pop && tq_data.unit == iafdm_pkg::UNIT_MUL) begin
            st_r <= S_MUL1;
          end else if (tq_pop && tq_data.unit == iafdm_pkg::UNIT_DIV) begin
            st_r <= S_DIV;
          end
          t_r <= tq_data;
          ua_r <= tq_data.operand_a[W-1] ? -tq_data.operand_a : tq_data.operand_a;
          ub_r <= tq_data.operand_b[W-1] ? -tq_data.operand_b : tq_data.operand_b;
          rem_r <= '0;
          cnt_r <= CW'(W);
        end
        S_MUL1: begin
          ll_r <= t_r.operand_a[HW-1:0] * t_r.operand_b[HW-1:0];
          lh_r <= t_r.operand_a[HW-1:0] * t_r.operand_b[W-1:HW];
          hl_r <= t_r.operand_a[W-1:HW] * t_r.operand_b[HW-1:0];
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          sum_r <= ll_r + {lh_r[HW-1:0] + hl_r[HW-1:0], {HW{1'b0}}};
          st_r <= S_FIX;
        end
        S_DIV: begin
          if (trial[W]) begin
            rem_r <= rem_sh;
            q_r <= {q_r[W-2:0], 1'b0};
          end else begin
            rem_r <= trial[W-1:0];
            q_r <= {q_r[W-2:0], 1'b1};
          end
          ua_r <= {ua_r[W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) st_r <= S_FIX;
        end
        S_FIX: begin
          if (t_r.unit == iafdm_pkg::UNIT_MUL) begin
            res_r <= sum_r;
          end else if (t_r.is_mod) begin
            // signs differ and remainder is nonzero: remainder moves to the divisor's side
            if (rem_r != '0 && aneg != bneg) begin
              res_r <= aneg ? t_r.operand_b - rem_r : t_r.operand_b + rem_r;
            end else begin
              res_r <= aneg ? -rem_r : rem_r;
            end
          end else begin
            if (aneg != bneg) res_r <= (rem_r != '0) ? ~q_r : -q_r;
            else res_r <= q_r;
          end
          out_v_r <= 1'b1;
          st_r <= S_DONE;
        end
        S_DONE: begin
          if (!res_full) begin
            out_v_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
